// ----- design/tcd_pkg.sv -----
// Shared constants and types of the tile change detector.
// Used by the channel interfaces and the core.
package tcd_pkg;

	localparam int TILE_SIZE   = 16;
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int PIXEL_BYTES = 4;

	localparam int PIX_W        = 32;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int WDIM_W       = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W       = $clog2(MAX_HEIGHT + 1);
	localparam int TILES_ACROSS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
	localparam int TILE_IDX_W   = $clog2(TILES_ACROSS);
	localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);

	localparam logic [PIX_W-1:0] PIX_MASK =
		PIX_W'((64'd1 << (8 * PIXEL_BYTES)) - 64'd1);

	// Configuration port.
	localparam int APB_DW  = 32;
	localparam int PADDR_W = 3;
	localparam int CFG_W   = 11;
	localparam logic [PADDR_W-3:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [PADDR_W-3:0] REG_FRAME_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0]   RESET_WIDTH      = 11'd640;
	localparam logic [CFG_W-1:0]   RESET_HEIGHT     = 11'd480;

	typedef struct packed {
		logic              tile_dirty;
		logic [COL_W-1:0]  tile_left;
		logic [ROW_W-1:0]  tile_top;
		logic [WDIM_W-1:0] tile_right;
		logic [HDIM_W-1:0] tile_bottom;
		logic              frame_end;
		logic              frame_changed;
	} tile_res_t;

endpackage

// ----- design/tcd_pixel_if.sv -----
// Pixel input channel: valid/ready handshake with one pixel per item.
// Depends on tcd_pkg for the pixel width.
interface tcd_pixel_if;
	import tcd_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

// ----- design/tcd_tile_if.sv -----
// Tile result channel: valid/ready handshake with one tile rectangle per item.
// Depends on tcd_pkg for the field widths.
interface tcd_tile_if;
	import tcd_pkg::*;

	logic              valid;
	logic              ready;
	logic              tile_dirty;
	logic [COL_W-1:0]  tile_left;
	logic [ROW_W-1:0]  tile_top;
	logic [WDIM_W-1:0] tile_right;
	logic [HDIM_W-1:0] tile_bottom;
	logic              frame_end;
	logic              frame_changed;

	modport source (output valid, output tile_dirty, output tile_left, output tile_top,
		output tile_right, output tile_bottom, output frame_end, output frame_changed,
		input ready);
	modport sink   (input valid, input tile_dirty, input tile_left, input tile_top,
		input tile_right, input tile_bottom, input frame_end, input frame_changed,
		output ready);
endinterface

// ----- design/tcd_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered data.
// A read of the address being written in the same cycle returns the old data.
module tcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end
endmodule

// ----- design/tile_change_detector_core.sv -----
// Tile change detector core. Depends on tcd_pkg, tcd_pixel_if, tcd_tile_if, tcd_ram.
//
// Pixels arrive on the pixels channel in raster order, one item per pixel. Each
// pixel is compared with the same position of the stored previous frame, which is
// then overwritten. At the last pixel of a 16x16 tile (clipped at the right and
// bottom edges) a dirty tile's rectangle is sent on the tiles channel; the frame's
// last pixel always sends one item with frame_end set and frame_changed telling
// whether any pixel of the frame differed.
// Throughput is one pixel per clock: the frame store and the tile flag store are
// read at the accept edge and written back in the next cycle, with a bypass when
// the next pixel hits the same entry. A result passes the stage 1 registers and
// the output queue before it is valid on the tiles channel. A two-entry output
// queue lets pixels keep flowing while a result waits; when the receiver stalls,
// ready drops once the queue and the pixel in flight could fill it.
// After reset, and after every write to frame_width or frame_height, the frame
// store is swept to zero, one entry per cycle over all 1,048,576 entries, while ready is
// low; the position restarts at the top left. The APB port holds frame_width at
// address 0 and frame_height at 4; write them only while the block is idle.
module tile_change_detector_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcd_pkg::PADDR_W-1:0]  paddr,
	input  logic [tcd_pkg::APB_DW-1:0]   pwdata,
	output logic [tcd_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	tcd_pixel_if.sink                    pixels,
	tcd_tile_if.source                   tiles
);
	import tcd_pkg::*;

	// Configuration registers.
	logic [CFG_W-1:0]       width_q;
	logic [CFG_W-1:0]       height_q;
	logic                   cfg_wr;
	logic [PADDR_W-3:0]     cfg_idx;
	logic [WDIM_W-1:0]      w_eff;
	logic [HDIM_W-1:0]      h_eff;

	// Clearing sweep.
	logic                   clearing_q;
	logic [ADDR_W-1:0]      clr_addr_q;

	// Position and frame state.
	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;
	logic                   any_q;

	// Stage 0, combinational from the position.
	logic                   accept;
	logic [WDIM_W-1:0]      col_next;
	logic [HDIM_W-1:0]      row_next;
	logic [COL_W-1:0]       left_s0;
	logic [ROW_W-1:0]       top_s0;
	logic [WDIM_W:0]        right_full;
	logic [HDIM_W:0]        bottom_full;
	logic [WDIM_W-1:0]      right_s0;
	logic [HDIM_W-1:0]      bottom_s0;
	logic [TILE_IDX_W-1:0]  tile_s0;
	logic [ADDR_W-1:0]      addr_s0;
	logic                   tile_end_s0;
	logic                   frame_done_s0;

	// Stage 1.
	logic                   s1_valid_q;
	logic [PIX_W-1:0]       px_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic [TILE_IDX_W-1:0]  tile_s1;
	logic [COL_W-1:0]       left_s1;
	logic [ROW_W-1:0]       top_s1;
	logic [WDIM_W-1:0]      right_s1;
	logic [HDIM_W-1:0]      bottom_s1;
	logic                   tile_end_s1;
	logic                   frame_done_s1;
	logic                   px_fwd_s1;
	logic [PIX_W-1:0]       px_fwd_data_s1;
	logic                   flag_fwd_s1;
	logic                   flag_fwd_data_s1;

	logic [PIX_W-1:0]       frame_rdata;
	logic                   flag_rdata;
	logic [PIX_W-1:0]       old_px;
	logic                   old_flag;
	logic                   diff;
	logic                   dirty;
	logic                   flag_wdata;
	logic                   push;
	tile_res_t              res;

	// RAM ports.
	logic                   frame_we;
	logic [ADDR_W-1:0]      frame_waddr;
	logic [PIX_W-1:0]       frame_wdata;
	logic                   flag_we;
	logic [TILE_IDX_W-1:0]  flag_waddr;
	logic                   flag_wval;

	// Output queue.
	tile_res_t              fifo_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             cnt_q;
	logic                   pop;
	logic [2:0]             load;

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[PADDR_W-1:2];

	always_comb begin
		case (cfg_idx)
			REG_FRAME_WIDTH:  prdata = APB_DW'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(height_q);
			default:          prdata = '0;
		endcase
	end

	// A zero size acts as one, a size above the maximum acts as the maximum.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WDIM_W'(1);
		end else if (WDIM_W'(width_q) > WDIM_W'(MAX_WIDTH)) begin
			w_eff = WDIM_W'(MAX_WIDTH);
		end else begin
			w_eff = WDIM_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HDIM_W'(1);
		end else if (HDIM_W'(height_q) > HDIM_W'(MAX_HEIGHT)) begin
			h_eff = HDIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = HDIM_W'(height_q);
		end
	end

	// ---------------- stage 0 ----------------
	assign load   = 3'(cnt_q) + 3'(s1_valid_q) - 3'(pop);
	assign pixels.ready = !clearing_q && (load <= 3'd1);
	assign accept = pixels.valid && pixels.ready;

	always_comb begin
		col_next    = WDIM_W'(col_q) + WDIM_W'(1);
		row_next    = HDIM_W'(row_q) + HDIM_W'(1);
		tile_s0     = TILE_IDX_W'(col_q / TILE_SIZE);
		left_s0     = COL_W'((col_q / TILE_SIZE) * TILE_SIZE);
		top_s0      = ROW_W'((row_q / TILE_SIZE) * TILE_SIZE);
		right_full  = (WDIM_W+1)'(left_s0) + (WDIM_W+1)'(TILE_SIZE);
		bottom_full = (HDIM_W+1)'(top_s0) + (HDIM_W+1)'(TILE_SIZE);
		right_s0    = (right_full > {1'b0, w_eff}) ? w_eff : WDIM_W'(right_full);
		bottom_s0   = (bottom_full > {1'b0, h_eff}) ? h_eff : HDIM_W'(bottom_full);
		tile_end_s0   = (col_next == right_s0) && (row_next == bottom_s0);
		frame_done_s0 = (col_next == w_eff) && (row_next == h_eff);
		addr_s0 = ADDR_W'(row_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RESET_WIDTH;
			height_q   <= RESET_HEIGHT;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			any_q      <= 1'b0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				if (frame_done_s0) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_next == w_eff) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (s1_valid_q) begin
				any_q <= frame_done_s1 ? 1'b0 : (any_q || diff);
			end
			// A size write abandons the frame and starts a new sweep of the store.
			if (cfg_wr) begin
				case (cfg_idx)
					REG_FRAME_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
					REG_FRAME_HEIGHT: height_q <= pwdata[CFG_W-1:0];
					default:          ;
				endcase
				clearing_q <= 1'b1;
				clr_addr_q <= '0;
				col_q      <= '0;
				row_q      <= '0;
				any_q      <= 1'b0;
			end
		end
	end

	// Stage 1 payload. The bypass covers a pixel read at the same edge at which
	// the pixel ahead of it writes the same entry back.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1          <= pixels.pixel_value & PIX_MASK;
			addr_s1        <= addr_s0;
			tile_s1        <= tile_s0;
			left_s1        <= left_s0;
			top_s1         <= top_s0;
			right_s1       <= right_s0;
			bottom_s1      <= bottom_s0;
			tile_end_s1    <= tile_end_s0;
			frame_done_s1  <= frame_done_s0;
			px_fwd_s1      <= s1_valid_q && (addr_s1 == addr_s0);
			px_fwd_data_s1 <= px_s1;
			flag_fwd_s1    <= s1_valid_q && (tile_s1 == tile_s0);
			flag_fwd_data_s1 <= flag_wdata;
		end
	end

	// ---------------- stage 1 ----------------
	always_comb begin
		old_px     = px_fwd_s1 ? px_fwd_data_s1 : frame_rdata;
		old_flag   = flag_fwd_s1 ? flag_fwd_data_s1 : flag_rdata;
		diff       = (old_px != px_s1);
		dirty      = old_flag || diff;
		flag_wdata = tile_end_s1 ? 1'b0 : dirty;
		push       = s1_valid_q && tile_end_s1 && (dirty || frame_done_s1);

		res.tile_dirty    = dirty;
		res.tile_left     = left_s1;
		res.tile_top      = top_s1;
		res.tile_right    = right_s1;
		res.tile_bottom   = bottom_s1;
		res.frame_end     = frame_done_s1;
		res.frame_changed = frame_done_s1 && (any_q || diff);

		if (clearing_q) begin
			frame_we    = 1'b1;
			frame_waddr = clr_addr_q;
			frame_wdata = '0;
			flag_we     = 1'b1;
			flag_waddr  = clr_addr_q[TILE_IDX_W-1:0];
			flag_wval   = 1'b0;
		end else begin
			frame_we    = s1_valid_q;
			frame_waddr = addr_s1;
			frame_wdata = px_s1;
			flag_we     = s1_valid_q;
			flag_waddr  = tile_s1;
			flag_wval   = flag_wdata;
		end
	end

	tcd_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (frame_we),
		.waddr (frame_waddr),
		.wdata (frame_wdata),
		.re    (accept),
		.raddr (addr_s0),
		.rdata (frame_rdata)
	);

	tcd_ram #(
		.WIDTH (1),
		.DEPTH (TILES_ACROSS)
	) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wval),
		.re    (accept),
		.raddr (tile_s0),
		.rdata (flag_rdata)
	);

	// ---------------- output queue ----------------
	assign pop         = tiles.valid && tiles.ready;
	assign tiles.valid = (cnt_q != 2'd0);

	always_comb begin
		tiles.tile_dirty    = fifo_q[rd_ptr_q].tile_dirty;
		tiles.tile_left     = fifo_q[rd_ptr_q].tile_left;
		tiles.tile_top      = fifo_q[rd_ptr_q].tile_top;
		tiles.tile_right    = fifo_q[rd_ptr_q].tile_right;
		tiles.tile_bottom   = fifo_q[rd_ptr_q].tile_bottom;
		tiles.frame_end     = fifo_q[rd_ptr_q].frame_end;
		tiles.frame_changed = fifo_q[rd_ptr_q].frame_changed;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// ---------------- assertions ----------------
	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2) || pop)
		else $error("result queue overflow");

	a_pos_in_frame : assert property (@(posedge clk) disable iff (!arst_n)
		(WDIM_W'(col_q) < w_eff) && (HDIM_W'(row_q) < h_eff))
		else $error("position outside the active frame");

	a_frame_end_result : assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && frame_done_s1 |-> push && res.frame_end)
		else $error("frame end without a result");

	a_frame_restart : assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_done_s0 |=> (col_q == '0) && (row_q == '0))
		else $error("position not restarted after frame end");

	a_sweep_done : assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clr_addr_q) == ADDR_W'(STORE_DEPTH - 1))
		else $error("store sweep ended early");

endmodule
